/* rtl/igfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package igfs_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned GainW   = 16;
  localparam int unsigned LenW    = 10;
  localparam int unsigned TapW    = 40;
  localparam int unsigned CoefW   = 18;
  localparam int unsigned AccW    = 64;
  localparam int unsigned CoefFrac = 17;
  localparam int unsigned CoefHalf = 26;

  localparam logic [0:0] RegGain   = 1'b0;
  localparam logic [0:0] RegLength = 1'b1;

  localparam logic signed [SampleW-1:0] Q23Max = 24'sd8388607;

  // First half of the symmetric Q1.17 impulse response; the rest mirrors it.
  function automatic logic signed [CoefW-1:0] coef_half(input logic [4:0] i);
    logic signed [CoefW-1:0] c;
    begin
      case (i)
        5'd0:  c = 18'sd67;
        5'd1:  c = 18'sd0;
        5'd2:  c = -18'sd86;
        5'd3:  c = 18'sd184;
        5'd4:  c = -18'sd272;
        5'd5:  c = 18'sd303;
        5'd6:  c = -18'sd225;
        5'd7:  c = 18'sd0;
        5'd8:  c = 18'sd360;
        5'd9:  c = -18'sd777;
        5'd10: c = 18'sd1106;
        5'd11: c = -18'sd1170;
        5'd12: c = 18'sd820;
        5'd13: c = 18'sd0;
        5'd14: c = -18'sd1187;
        5'd15: c = 18'sd2463;
        5'd16: c = -18'sd3409;
        5'd17: c = 18'sd3550;
        5'd18: c = -18'sd2481;
        5'd19: c = 18'sd0;
        5'd20: c = 18'sd3803;
        5'd21: c = -18'sd8513;
        5'd22: c = 18'sd13448;
        5'd23: c = -18'sd17792;
        5'd24: c = 18'sd20770;
        5'd25: c = 18'sd109147;
        default: c = 18'sd0;
      endcase
      return c;
    end
  endfunction

  // Coefficient of tap i for the 51-tap response, zero beyond it.
  function automatic logic signed [CoefW-1:0] coef_at(input logic [6:0] i);
    begin
      if (i < 7'(CoefHalf)) return coef_half(i[4:0]);
      if (i <= 7'd50) return coef_half(5'(7'd50 - i));
      return '0;
    end
  endfunction

  // Saturation of a wide signed value to +/-(2^23-1).
  function automatic logic signed [SampleW-1:0] sat_q23(input logic signed [AccW-1:0] v);
    begin
      if (v > AccW'(Q23Max)) return Q23Max;
      if (v < -AccW'(Q23Max)) return -Q23Max;
      return v[SampleW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/i2s_gain_fir_snapshot_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Gained 51-tap low-pass snapshot recorder. Each transfer on the input takes one I2S word,
// scales its top 24 bits by input_gain and pushes it into a chain of tap cells. The taps then
// rotate once around the chain past a single multiply-accumulate unit, and the rounded and
// saturated sum is registered as the result; the next input is taken as soon as the result
// register is free. After snapshot_length samples the block drops every input until reset.
// Configuration writes are taken at any time the block is idle.
module i2s_gain_fir_snapshot_unit #(
  parameter int unsigned TAP_COUNT    = 51,
  parameter int unsigned SNAPSHOT_MAX = 512
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [15:0]                   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [31:0]            i2s_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [igfs_pkg::SampleW-1:0] raw_sample_o,
  output logic signed [igfs_pkg::SampleW-1:0] filtered_sample_o,
  output logic [8:0]                         sample_index_o,
  output logic                               last_of_snapshot_o
);
  import igfs_pkg::*;

  localparam int unsigned CntW = $clog2(TAP_COUNT + 1);
  localparam int unsigned SnapW = $clog2(SNAPSHOT_MAX + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND
  } state_e;

  state_e state_q;
  logic [GainW-1:0] gain_q;
  logic [LenW-1:0]  len_q;
  logic [SnapW-1:0] count_q;
  logic             full_q;
  logic [CntW-1:0]  step_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [TapW-1:0] x_q;
  logic signed [AccW-1:0] prod_q;
  logic             prod_vld_q;
  logic [8:0]       idx_q;
  logic             last_q;

  logic signed [TapW-1:0] taps [TAP_COUNT];
  logic                   shift, rot, accept;
  logic signed [TapW-1:0] x_new;
  logic [SnapW-1:0]       limit;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 16'd15000;
      len_q  <= 10'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGain:   gain_q <= cfg_data_i;
        RegLength: len_q  <= cfg_data_i[LenW-1:0];
        default:   gain_q <= gain_q;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_o;
  assign accept     = in_valid_i && in_ready_o;
  assign shift      = accept && !full_q;
  assign rot        = (state_q == ST_MAC) && (step_q < CntW'(TAP_COUNT));
  assign x_new      = TapW'(signed'(i2s_word_i[31:8])) * signed'({1'b0, gain_q});

  // Length zero acts as one; lengths above the maximum clamp to it.
  always_comb begin
    if (32'(len_q) > SNAPSHOT_MAX) begin
      limit = SnapW'(SNAPSHOT_MAX);
    end else if (len_q == '0) begin
      limit = SnapW'(1);
    end else begin
      limit = SnapW'(len_q);
    end
  end

  // Chain of tap cells; while rotating the head wraps to the tail, so the tap with
  // delay k sits at the head on step k.
  for (genvar g = 0; g < TAP_COUNT; g++) begin : g_tap
    igfs_tap_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .rot_i  (rot),
      .load_i ((g == 0) ? x_new : taps[(g == 0) ? 0 : g-1]),
      .prev_i ((g == TAP_COUNT-1) ? taps[0] : taps[(g == TAP_COUNT-1) ? 0 : g+1]),
      .tap_o  (taps[g])
    );
  end

  // Sequencer: rotate through the taps, multiply one per cycle, then round and saturate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      acc_q       <= '0;
      prod_vld_q  <= 1'b0;
      count_q     <= '0;
      full_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      prod_vld_q <= rot;
      if (rot) begin
        prod_q <= AccW'(taps[0]) * AccW'(coef_at(7'(step_q)));
      end
      if (prod_vld_q) begin
        acc_q <= acc_q + prod_q;
      end
      case (state_q)
        ST_IDLE: begin
          if (shift) begin
            x_q     <= x_new;
            idx_q   <= count_q[8:0];
            last_q  <= (count_q + 1'b1) >= limit;
            full_q  <= (count_q + 1'b1) >= limit;
            count_q <= count_q + 1'b1;
            acc_q   <= '0;
            step_q  <= '0;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (rot) begin
            step_q <= step_q + 1'b1;
          end else if (!prod_vld_q) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          raw_sample_o       <= sat_q23(AccW'(x_q));
          filtered_sample_o  <= sat_q23((acc_q + AccW'(1 << (CoefFrac - 1))) >>> CoefFrac);
          sample_index_o     <= idx_q;
          last_of_snapshot_o <= last_q;
          out_valid_o        <= 1'b1;
          state_q            <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/igfs_tap_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module igfs_tap_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          shift_i,
  input  wire logic                          rot_i,
  input  wire logic signed [igfs_pkg::TapW-1:0] load_i,
  input  wire logic signed [igfs_pkg::TapW-1:0] prev_i,
  output logic signed [igfs_pkg::TapW-1:0]      tap_o
);
  import igfs_pkg::*;

  logic signed [TapW-1:0] tap_q, tap_d;

  // A new sample shifts in; during the sum the taps rotate past the MAC.
  always_comb begin
    tap_d = tap_q;
    if (shift_i) begin
      tap_d = load_i;
    end else if (rot_i) begin
      tap_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else begin
      tap_q <= tap_d;
    end
  end

  assign tap_o = tap_q;
endmodule
`default_nettype wire

/* rtl/igfs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module igfs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [8:0] sample_index_o,
  input wire logic       last_of_snapshot_o,
  input wire logic signed [23:0] raw_sample_o
);
  // A result that waits stays valid and holds its sample index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_index_o))
    else $error("stalled result changed");

  // No new input is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");

  // The raw value never reaches the negative full scale code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> raw_sample_o != 24'h800000)
    else $error("raw sample out of range");

  // Once the final result of a snapshot is taken, out_valid_o drops.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_of_snapshot_o |=> !out_valid_o)
    else $error("result after snapshot end");
endmodule

bind i2s_gain_fir_snapshot_unit igfs_checker u_igfs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .sample_index_o    (sample_index_o),
  .last_of_snapshot_o(last_of_snapshot_o),
  .raw_sample_o      (raw_sample_o)
);
`default_nettype wire
